FILE: rtl/reference_satellite_hysteresis_macros.svh
`ifndef REFERENCE_SATELLITE_HYSTERESIS_MACROS_SVH
`define REFERENCE_SATELLITE_HYSTERESIS_MACROS_SVH

// same-cycle implication, quiet during reset
`define RSH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define RSH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked through reset
`define RSH_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rsh_pkg.sv
package rsh_pkg;

    localparam int SAT_W      = 8;
    localparam int ELEV_W     = 15;
    localparam int STREAK_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_START = 1'b0;

    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_EPOCHS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETURN_MIN_ELEV  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELEV_DROP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SWITCH_ELEV  = 2'd3;

    // request classes
    localparam logic [1:0] KIND_START = 2'd0;  // epoch start, candidates follow
    localparam logic [1:0] KIND_EMPTY = 2'd1;  // epoch start with no candidates
    localparam logic [1:0] KIND_CAND  = 2'd2;  // candidate
    localparam logic [1:0] KIND_CLOSE = 2'd3;  // final candidate of the epoch

    typedef struct packed {
        logic [1:0]               kind;
        logic [SAT_W-1:0]         sat_id;
        logic signed [ELEV_W-1:0] elevation;
        logic                     suspect;
        logic                     dual_freq;
    } t_item;

endpackage

FILE: rtl/rsh_in_if.sv
interface rsh_in_if;
    import rsh_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [SAT_W-1:0]         sat_id;
    logic signed [ELEV_W-1:0] elevation;
    logic                     suspect;
    logic                     dual_freq;
    logic                     last;

    modport source (output valid, cmd, sat_id, elevation, suspect, dual_freq, last,
                    input ready);
    modport sink   (input valid, cmd, sat_id, elevation, suspect, dual_freq, last,
                    output ready);
endinterface

FILE: rtl/rsh_out_if.sv
interface rsh_out_if;
    import rsh_pkg::*;

    logic             valid;
    logic             ready;
    logic             valid_res;
    logic [SAT_W-1:0] reference_sat;
    logic             switched;

    modport source (output valid, valid_res, reference_sat, switched, input ready);
    modport sink   (input valid, valid_res, reference_sat, switched, output ready);
endinterface

FILE: rtl/rsh_front.sv
module rsh_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rsh_in_if.sink        i_req,
    input  logic          i_q_full,
    output logic          o_push,
    output rsh_pkg::t_item o_item
);
    import rsh_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_push      = r_valid && !i_q_full;
    assign i_req.ready = !r_valid || !i_q_full;
    assign o_item      = r_item;

    always_comb begin
        n_item.sat_id    = i_req.sat_id;
        n_item.elevation = i_req.elevation;
        n_item.suspect   = i_req.suspect;
        n_item.dual_freq = i_req.dual_freq;
        if (i_req.cmd == CMD_START) begin
            n_item.kind = i_req.last ? KIND_EMPTY : KIND_START;
        end else begin
            n_item.kind = i_req.last ? KIND_CLOSE : KIND_CAND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item <= n_item;
        end
    end
endmodule

FILE: rtl/rsh_queue.sv
module rsh_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rsh_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_head_valid,
    output rsh_pkg::t_item o_head
);
    import rsh_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end
endmodule

FILE: rtl/rsh_back.sv
module rsh_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rsh_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rsh_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_head_valid,
    input  rsh_pkg::t_item                    i_head,
    output logic                              o_pop,
    rsh_out_if.source                         o_res
);
    import rsh_pkg::*;

    function automatic logic [STREAK_W-1:0] f_sat_inc(input logic [STREAK_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // configuration
    logic [STREAK_W-1:0]      r_switch_epochs;
    logic [ELEV_W-1:0]        r_ret_min;
    logic [ELEV_W-1:0]        r_max_drop;
    logic signed [ELEV_W-1:0] r_min_elev;

    // tracked state
    logic [SAT_W-1:0]    r_cur_ref,    n_cur_ref;
    logic                r_have_ref,   n_have_ref;
    logic [STREAK_W-1:0] r_susp_str,   n_susp_str;
    logic [SAT_W-1:0]    r_ret_sat,    n_ret_sat;
    logic                r_have_ret,   n_have_ret;
    logic [STREAK_W-1:0] r_ret_str,    n_ret_str;
    logic [SAT_W-1:0]    r_nat_ref,    n_nat_ref;
    logic signed [ELEV_W-1:0] r_nat_elev, n_nat_elev;

    // epoch lookups
    logic                     r_cm_found, n_cm_found;
    logic                     r_cm_susp,  n_cm_susp;
    logic signed [ELEV_W-1:0] r_cm_elev,  n_cm_elev;
    logic                     r_any_v,    n_any_v;
    logic [SAT_W-1:0]         r_any_sat,  n_any_sat;
    logic signed [ELEV_W-1:0] r_any_elev, n_any_elev;
    logic                     r_dual_v,   n_dual_v;
    logic [SAT_W-1:0]         r_dual_sat, n_dual_sat;
    logic signed [ELEV_W-1:0] r_dual_elev, n_dual_elev;
    logic                     r_nm_found, n_nm_found;
    logic                     r_nm_susp,  n_nm_susp;

    logic r_close_pend, n_close_pend;

    // output register
    logic             r_o_valid, n_o_valid;
    logic             r_o_res,   n_o_res;
    logic [SAT_W-1:0] r_o_sat,   n_o_sat;
    logic             r_o_sw,    n_o_sw;

    logic emit_ok, close_go, head_blocked, pop, produce;

    // close datapath
    logic                     boot, cvalid, gate, sw_away, cond, nsus, same_ret;
    logic [SAT_W-1:0]         csat, cur1;
    logic signed [ELEV_W-1:0] celev, after_elev;
    logic signed [ELEV_W+1:0] drop_diff, nat_thr;
    logic [STREAK_W-1:0]      ss1, rs;

    assign emit_ok  = !r_o_valid || o_res.ready;
    assign close_go = r_close_pend && emit_ok;

    always_comb begin
        if (r_close_pend) begin
            head_blocked = !emit_ok || (i_head.kind != KIND_START);
        end else begin
            head_blocked = (i_head.kind == KIND_EMPTY) && !emit_ok;
        end
    end

    assign pop   = i_head_valid && !head_blocked;
    assign o_pop = pop;

    always_comb begin
        boot      = !r_have_ref || !r_cm_found;
        ss1       = r_cm_susp ? f_sat_inc(r_susp_str) : '0;
        cvalid    = r_dual_v || r_any_v;
        csat      = r_dual_v ? r_dual_sat : r_any_sat;
        celev     = r_dual_v ? r_dual_elev : r_any_elev;
        drop_diff = (ELEV_W+2)'(r_cm_elev) - (ELEV_W+2)'(celev);
        gate      = (celev >= r_min_elev) &&
                    (drop_diff <= $signed({2'b00, r_max_drop}));
        sw_away   = (ss1 >= r_switch_epochs) && cvalid && (csat != r_cur_ref) && gate;
        cur1      = sw_away ? csat : r_cur_ref;
        after_elev = sw_away ? celev : r_cm_elev;
        nat_thr   = (ELEV_W+2)'(after_elev) + $signed({2'b00, r_ret_min});
        cond      = (r_nat_ref != cur1) && ((ELEV_W+2)'(r_nat_elev) > nat_thr);
        nsus      = !r_nm_found || r_nm_susp;
        same_ret  = !sw_away && r_have_ret && (r_ret_sat == r_nat_ref);
        if (nsus) begin
            rs = '0;
        end else if (same_ret) begin
            rs = f_sat_inc(r_ret_str);
        end else begin
            rs = STREAK_W'(1);
        end
    end

    always_comb begin
        n_cur_ref   = r_cur_ref;
        n_have_ref  = r_have_ref;
        n_susp_str  = r_susp_str;
        n_ret_sat   = r_ret_sat;
        n_have_ret  = r_have_ret;
        n_ret_str   = r_ret_str;
        n_nat_ref   = r_nat_ref;
        n_nat_elev  = r_nat_elev;
        n_cm_found  = r_cm_found;
        n_cm_susp   = r_cm_susp;
        n_cm_elev   = r_cm_elev;
        n_any_v     = r_any_v;
        n_any_sat   = r_any_sat;
        n_any_elev  = r_any_elev;
        n_dual_v    = r_dual_v;
        n_dual_sat  = r_dual_sat;
        n_dual_elev = r_dual_elev;
        n_nm_found  = r_nm_found;
        n_nm_susp   = r_nm_susp;
        n_close_pend = r_close_pend;
        produce     = 1'b0;
        n_o_res     = r_o_res;
        n_o_sat     = r_o_sat;
        n_o_sw      = r_o_sw;

        if (close_go) begin
            n_close_pend = 1'b0;
            produce      = 1'b1;
            n_o_res      = 1'b1;
            if (boot) begin
                n_cur_ref  = r_nat_ref;
                n_have_ref = 1'b1;
                n_susp_str = '0;
                n_have_ret = 1'b0;
                n_ret_str  = '0;
            end else begin
                n_cur_ref  = cur1;
                n_susp_str = sw_away ? '0 : ss1;
                if (cond) begin
                    n_ret_sat  = r_nat_ref;
                    n_have_ret = 1'b1;
                    n_ret_str  = rs;
                    if (rs >= r_switch_epochs) begin
                        n_cur_ref  = r_nat_ref;
                        n_susp_str = '0;
                        n_have_ret = 1'b0;
                        n_ret_str  = '0;
                    end
                end else begin
                    n_have_ret = 1'b0;
                    n_ret_str  = '0;
                end
            end
            n_o_sat = n_cur_ref;
            n_o_sw  = (boot ? r_have_ref : 1'b1) && (n_cur_ref != r_cur_ref);
            n_cm_found = 1'b0; n_cm_susp = 1'b0; n_cm_elev = '0;
            n_any_v    = 1'b0; n_any_sat = '0;   n_any_elev = '0;
            n_dual_v   = 1'b0; n_dual_sat = '0;  n_dual_elev = '0;
            n_nm_found = 1'b0; n_nm_susp = 1'b0;
        end

        if (pop) begin
            if (i_head.kind == KIND_START || i_head.kind == KIND_EMPTY) begin
                n_nat_ref  = i_head.sat_id;
                n_nat_elev = i_head.elevation;
                n_cm_found = 1'b0; n_cm_susp = 1'b0; n_cm_elev = '0;
                n_any_v    = 1'b0; n_any_sat = '0;   n_any_elev = '0;
                n_dual_v   = 1'b0; n_dual_sat = '0;  n_dual_elev = '0;
                n_nm_found = 1'b0; n_nm_susp = 1'b0;
                if (i_head.kind == KIND_EMPTY) begin
                    produce = 1'b1;
                    n_o_res = 1'b0;
                    n_o_sat = '0;
                    n_o_sw  = 1'b0;
                end
            end else begin
                if (r_have_ref && !r_cm_found && i_head.sat_id == r_cur_ref) begin
                    n_cm_found = 1'b1;
                    n_cm_susp  = i_head.suspect;
                    n_cm_elev  = i_head.elevation;
                end
                if (!r_nm_found && i_head.sat_id == r_nat_ref) begin
                    n_nm_found = 1'b1;
                    n_nm_susp  = i_head.suspect;
                end
                if (!i_head.suspect) begin
                    if (!r_any_v || i_head.elevation > r_any_elev) begin
                        n_any_v    = 1'b1;
                        n_any_sat  = i_head.sat_id;
                        n_any_elev = i_head.elevation;
                    end
                    if (i_head.dual_freq &&
                        (!r_dual_v || i_head.elevation > r_dual_elev)) begin
                        n_dual_v    = 1'b1;
                        n_dual_sat  = i_head.sat_id;
                        n_dual_elev = i_head.elevation;
                    end
                end
                if (i_head.kind == KIND_CLOSE) begin
                    n_close_pend = 1'b1;
                end
            end
        end

        n_o_valid = produce || (r_o_valid && !o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_switch_epochs <= STREAK_W'(3);
            r_ret_min       <= ELEV_W'(873);
            r_max_drop      <= ELEV_W'(31416);
            r_min_elev      <= '0;
            r_cur_ref       <= '0;
            r_have_ref      <= 1'b0;
            r_susp_str      <= '0;
            r_ret_sat       <= '0;
            r_have_ret      <= 1'b0;
            r_ret_str       <= '0;
            r_nat_ref       <= '0;
            r_nat_elev      <= '0;
            r_cm_found      <= 1'b0;
            r_cm_susp       <= 1'b0;
            r_cm_elev       <= '0;
            r_any_v         <= 1'b0;
            r_any_sat       <= '0;
            r_any_elev      <= '0;
            r_dual_v        <= 1'b0;
            r_dual_sat      <= '0;
            r_dual_elev     <= '0;
            r_nm_found      <= 1'b0;
            r_nm_susp       <= 1'b0;
            r_close_pend    <= 1'b0;
            r_o_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SWITCH_EPOCHS:   r_switch_epochs <= i_cfg_data[STREAK_W-1:0];
                    CFG_RETURN_MIN_ELEV: r_ret_min       <= i_cfg_data[ELEV_W-1:0];
                    CFG_MAX_ELEV_DROP:   r_max_drop      <= i_cfg_data[ELEV_W-1:0];
                    CFG_MIN_SWITCH_ELEV: r_min_elev      <= $signed(i_cfg_data[ELEV_W-1:0]);
                    default: ;
                endcase
            end
            r_cur_ref    <= n_cur_ref;
            r_have_ref   <= n_have_ref;
            r_susp_str   <= n_susp_str;
            r_ret_sat    <= n_ret_sat;
            r_have_ret   <= n_have_ret;
            r_ret_str    <= n_ret_str;
            r_nat_ref    <= n_nat_ref;
            r_nat_elev   <= n_nat_elev;
            r_cm_found   <= n_cm_found;
            r_cm_susp    <= n_cm_susp;
            r_cm_elev    <= n_cm_elev;
            r_any_v      <= n_any_v;
            r_any_sat    <= n_any_sat;
            r_any_elev   <= n_any_elev;
            r_dual_v     <= n_dual_v;
            r_dual_sat   <= n_dual_sat;
            r_dual_elev  <= n_dual_elev;
            r_nm_found   <= n_nm_found;
            r_nm_susp    <= n_nm_susp;
            r_close_pend <= n_close_pend;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_res <= n_o_res;
        r_o_sat <= n_o_sat;
        r_o_sw  <= n_o_sw;
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.valid_res     = r_o_res;
    assign o_res.reference_sat = r_o_sat;
    assign o_res.switched      = r_o_sw;
endmodule

FILE: rtl/reference_satellite_hysteresis.sv
// Reference satellite selector with hysteresis. Requests enter an input
// register that classifies them (epoch start, empty epoch, candidate, final
// candidate) and a four-entry queue; the back end updates the epoch lookups
// at one request per cycle unless a stalled output or a pending close holds
// it; the final candidate sets a pending close, which is carried out once
// the output register can take the result, and the start of the next epoch
// is taken in the same cycle as the close. A candidate that follows a close
// without a start request, or an empty epoch that follows a close, waits
// until the close is done. Results leave through a registered output. The
// user must write configuration through the plain write port only while no
// epoch is in flight; the block itself does not enforce this.
module reference_satellite_hysteresis (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rsh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rsh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rsh_in_if.sink                         i_req,
    rsh_out_if.source                      o_res
);
    import rsh_pkg::*;

    logic  push, q_full, pop, head_valid;
    t_item front_item, head_item;

    rsh_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (front_item)
    );

    rsh_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (front_item),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head_item)
    );

    rsh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (head_valid),
        .i_head       (head_item),
        .o_pop        (pop),
        .o_res        (o_res)
    );
endmodule

FILE: rtl/rsh_checker.sv
`include "reference_satellite_hysteresis_macros.svh"

module rsh_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_out_valid_res,
    input logic [rsh_pkg::SAT_W-1:0] i_out_sat,
    input logic                      i_out_switched
);
    import rsh_pkg::*;

    `RSH_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `RSH_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_sat) && $stable(i_out_switched) && $stable(i_out_valid_res), "result changed while stalled")
    `RSH_ASSERT_NOW(a_empty_clean, i_out_valid && !i_out_valid_res, i_out_sat == '0 && !i_out_switched, "empty epoch result carries data")
    `RSH_ASSERT_ALWAYS_NEXT(a_rst_quiet, !i_rst_n, !i_out_valid, "result presented right after reset")
endmodule

bind reference_satellite_hysteresis rsh_checker u_rsh_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_out_valid_res (o_res.valid_res),
    .i_out_sat       (o_res.reference_sat),
    .i_out_switched  (o_res.switched)
);

FILE: verif/rsh_selection_checker.sv
`timescale 1ns / 100ps

module rsh_selection_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rsh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rsh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rsh_in_if                              i_req_mon,
    rsh_out_if                             i_res_mon,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_results,
    output int                             o_switches
);
    import rsh_pkg::*;

    typedef struct packed {
        logic             valid_res;
        logic [SAT_W-1:0] reference_sat;
        logic             switched;
    } t_selection;

    t_selection selections_due[$];

    // register copies
    logic [STREAK_W-1:0] cfg_switch_epochs;
    int                  cfg_return_min;
    int                  cfg_max_drop;
    int                  cfg_min_switch;

    // tracked state
    logic [SAT_W-1:0]    cur_ref;
    logic                have_ref;
    logic [STREAK_W-1:0] suspect_run;
    logic [SAT_W-1:0]    return_sat;
    logic                have_return;
    logic [STREAK_W-1:0] clean_run;
    logic [SAT_W-1:0]    natural_sat;
    int                  natural_elev;

    // epoch lookups
    logic                cur_found, cur_suspect;
    int                  cur_elev;
    logic                any_valid, dual_valid;
    logic [SAT_W-1:0]    any_sat, dual_sat;
    int                  any_elev, dual_elev;
    logic                nat_found, nat_suspect;

    function automatic logic [STREAK_W-1:0] bump(input logic [STREAK_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic clear_lookups();
        cur_found = 1'b0; cur_suspect = 1'b0; cur_elev = 0;
        any_valid = 1'b0; any_sat = '0; any_elev = 0;
        dual_valid = 1'b0; dual_sat = '0; dual_elev = 0;
        nat_found = 1'b0; nat_suspect = 1'b0;
    endtask

    task automatic drop_return();
        have_return = 1'b0;
        clean_run = '0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        o_fail_count++;
        $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic predict_selection(input logic cmd, input logic [SAT_W-1:0] sat,
                                     input int elev, input logic sus, input logic dual,
                                     input logic last);
        t_selection       res;
        logic [SAT_W-1:0] prev;
        logic             had;
        logic             cand_valid;
        logic [SAT_W-1:0] cand_sat;
        int               cand_elev;
        int               cur_after;
        logic             nat_bad;
        if (cmd == CMD_START) begin
            natural_sat  = sat;
            natural_elev = elev;
            clear_lookups();
            if (last) begin
                res = '0;
                selections_due.push_back(res);
            end
            return;
        end
        if (have_ref && !cur_found && sat == cur_ref) begin
            cur_found = 1'b1; cur_suspect = sus; cur_elev = elev;
        end
        if (!nat_found && sat == natural_sat) begin
            nat_found = 1'b1; nat_suspect = sus;
        end
        if (!sus) begin
            if (!any_valid || elev > any_elev) begin
                any_valid = 1'b1; any_sat = sat; any_elev = elev;
            end
            if (dual && (!dual_valid || elev > dual_elev)) begin
                dual_valid = 1'b1; dual_sat = sat; dual_elev = elev;
            end
        end
        if (!last) return;

        prev = cur_ref;
        res.valid_res = 1'b1;
        if (!have_ref || !cur_found) begin
            // bootstrap or reacquire the natural pick
            had         = have_ref;
            cur_ref     = natural_sat;
            have_ref    = 1'b1;
            suspect_run = '0;
            drop_return();
            res.switched = had && (prev != cur_ref);
        end else begin
            cur_after   = cur_elev;
            suspect_run = cur_suspect ? bump(suspect_run) : '0;
            if (suspect_run >= cfg_switch_epochs) begin
                cand_valid = dual_valid || any_valid;
                cand_sat   = dual_valid ? dual_sat : any_sat;
                cand_elev  = dual_valid ? dual_elev : any_elev;
                if (cand_valid && cand_sat != cur_ref && cand_elev >= cfg_min_switch &&
                    (cur_elev - cand_elev) <= cfg_max_drop) begin
                    cur_ref     = cand_sat;
                    cur_after   = cand_elev;
                    suspect_run = '0;
                    drop_return();
                end
            end
            if (natural_sat != cur_ref && natural_elev > cur_after + cfg_return_min) begin
                nat_bad = !nat_found || nat_suspect;
                if (have_return && return_sat == natural_sat) begin
                    clean_run = nat_bad ? '0 : bump(clean_run);
                end else begin
                    return_sat  = natural_sat;
                    have_return = 1'b1;
                    clean_run   = nat_bad ? '0 : STREAK_W'(1);
                end
                if (clean_run >= cfg_switch_epochs) begin
                    cur_ref     = natural_sat;
                    suspect_run = '0;
                    drop_return();
                end
            end else begin
                drop_return();
            end
            res.switched = (prev != cur_ref);
        end
        res.reference_sat = cur_ref;
        selections_due.push_back(res);
        clear_lookups();
    endtask

    always @(posedge i_clk) begin
        t_selection want;
        if (!i_rst_n) begin
            cfg_switch_epochs = 8'd3;
            cfg_return_min    = 873;
            cfg_max_drop      = 31416;
            cfg_min_switch    = 0;
            cur_ref      = '0; have_ref = 1'b0; suspect_run = '0;
            return_sat   = '0; drop_return();
            natural_sat  = '0; natural_elev = 0;
            clear_lookups();
            selections_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SWITCH_EPOCHS:   cfg_switch_epochs = i_cfg_data[STREAK_W-1:0];
                    CFG_RETURN_MIN_ELEV: cfg_return_min    = int'(i_cfg_data);
                    CFG_MAX_ELEV_DROP:   cfg_max_drop      = int'(i_cfg_data);
                    CFG_MIN_SWITCH_ELEV: cfg_min_switch    = int'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            // compare before predicting: a result never belongs to this cycle's request
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (selections_due.size() == 0) begin
                    report_mismatch("result with none due, sat", i_res_mon.reference_sat, -1);
                end else begin
                    want = selections_due.pop_front();
                    o_results++;
                    if (i_res_mon.switched) o_switches++;
                    if (i_res_mon.valid_res !== want.valid_res)
                        report_mismatch("valid_res", i_res_mon.valid_res, want.valid_res);
                    if (i_res_mon.reference_sat !== want.reference_sat)
                        report_mismatch("reference_sat", i_res_mon.reference_sat,
                                        want.reference_sat);
                    if (i_res_mon.switched !== want.switched)
                        report_mismatch("switched", i_res_mon.switched, want.switched);
                end
            end
            if (i_req_mon.valid && i_req_mon.ready)
                predict_selection(i_req_mon.cmd, i_req_mon.sat_id, int'(i_req_mon.elevation),
                                  i_req_mon.suspect, i_req_mon.dual_freq,
                                  i_req_mon.last);
        end
        o_pending = selections_due.size();
    end

endmodule

FILE: verif/reference_satellite_hysteresis_tb.sv
`timescale 1ns / 100ps

module reference_satellite_hysteresis_tb;
    import rsh_pkg::*;

    localparam logic CMD_CANDIDATE = ~CMD_START;
    localparam int   ELEV_MAX      = 15708;
    localparam int   DRAIN_CYCLES  = 8;

    typedef enum int {IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY, IDLE_NONE} t_idle_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rsh_in_if  req_if ();
    rsh_out_if res_if ();

    int fail_count, pending, results, switches;
    int sent_count;
    t_idle_mode idle_mode;

    logic [SAT_W-1:0] pool_ids [8] = '{8'd0, 8'd3, 8'd17, 8'd42, 8'd99, 8'd128, 8'd200, 8'd255};
    int               pool_elev [8];
    logic             pool_bad [8];
    int               nat_pick;

    reference_satellite_hysteresis dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    rsh_selection_checker selection_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req_mon    (req_if),
        .i_res_mon    (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_switches   (switches)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial res_if.ready = 1'b0;
    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_SENDER_LIGHT: res_if.ready <= ($urandom_range(0, 99) >= 54);
            IDLE_SENDER_HEAVY: res_if.ready <= ($urandom_range(0, 99) >= 35);
            default:           res_if.ready <= 1'b1;
        endcase
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int clamp_elev(input int v);
        return (v > ELEV_MAX) ? ELEV_MAX : (v < -ELEV_MAX) ? -ELEV_MAX : v;
    endfunction

    function automatic int any_elev();
        case ($urandom_range(0, 9))
            0:       return -ELEV_MAX;
            1:       return ELEV_MAX;
            default: return int'($urandom_range(0, 2 * ELEV_MAX)) - ELEV_MAX;
        endcase
    endfunction

    task automatic send_request(input logic cmd, input logic [SAT_W-1:0] sat, input int elev,
                                input logic sus, input logic dual, input logic last);
        int idle_pct;
        idle_pct = (idle_mode == IDLE_SENDER_LIGHT) ? 35 :
                   (idle_mode == IDLE_SENDER_HEAVY) ? 54 : 0;
        while ($urandom_range(0, 99) < idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid     = 1'b1;
        req_if.cmd       = cmd;
        req_if.sat_id    = sat;
        req_if.elevation = elev[ELEV_W-1:0];
        req_if.suspect   = sus;
        req_if.dual_freq = dual;
        req_if.last      = last;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic drain();
        req_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic apply_settings(input int epochs, input int ret_min, input int drop,
                                  input int min_sw);
        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = CFG_SWITCH_EPOCHS;   i_cfg_data = epochs[CFG_DATA_W-1:0];  @(negedge i_clk);
        i_cfg_idx = CFG_RETURN_MIN_ELEV; i_cfg_data = ret_min[CFG_DATA_W-1:0]; @(negedge i_clk);
        i_cfg_idx = CFG_MAX_ELEV_DROP;   i_cfg_data = drop[CFG_DATA_W-1:0];    @(negedge i_clk);
        i_cfg_idx = CFG_MIN_SWITCH_ELEV; i_cfg_data = min_sw[CFG_DATA_W-1:0];  @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic directed_requests();
        // empty epoch before any reference
        send_request(CMD_START, 8'd0, 0, 1'b0, 1'b0, 1'b1);
        // bootstrap at the elevation extremes
        send_request(CMD_START, 8'd5, ELEV_MAX, 1'b0, 1'b0, 1'b0);
        send_request(CMD_CANDIDATE, 8'd5, ELEV_MAX, 1'b0, 1'b1, 1'b0);
        send_request(CMD_CANDIDATE, 8'd255, -ELEV_MAX, 1'b1, 1'b0, 1'b1);
        // switch away to a duplicated dual-frequency candidate
        send_request(CMD_START, 8'd5, ELEV_MAX, 1'b0, 1'b0, 1'b0);
        send_request(CMD_CANDIDATE, 8'd5, ELEV_MAX, 1'b1, 1'b1, 1'b0);
        send_request(CMD_CANDIDATE, 8'd200, 1000, 1'b0, 1'b1, 1'b0);
        send_request(CMD_CANDIDATE, 8'd200, 900, 1'b0, 1'b1, 1'b0);
        send_request(CMD_CANDIDATE, 8'd7, 3000, 1'b0, 1'b0, 1'b1);
        // clean natural pick brings it back
        send_request(CMD_START, 8'd5, ELEV_MAX, 1'b0, 1'b0, 1'b0);
        send_request(CMD_CANDIDATE, 8'd200, 1000, 1'b0, 1'b0, 1'b0);
        send_request(CMD_CANDIDATE, 8'd5, ELEV_MAX, 1'b0, 1'b0, 1'b1);
        // candidates with no start
        send_request(CMD_CANDIDATE, 8'd9, 100, 1'b0, 1'b1, 1'b0);
        send_request(CMD_CANDIDATE, 8'd5, 200, 1'b0, 1'b0, 1'b1);
        // current reference absent
        send_request(CMD_START, 8'd12, -ELEV_MAX, 1'b1, 1'b1, 1'b0);
        send_request(CMD_CANDIDATE, 8'd30, 500, 1'b0, 1'b0, 1'b1);
        // abandoned start, then only suspect candidates
        send_request(CMD_START, 8'd40, 0, 1'b0, 1'b0, 1'b0);
        send_request(CMD_START, 8'd12, 100, 1'b0, 1'b0, 1'b0);
        send_request(CMD_CANDIDATE, 8'd12, -ELEV_MAX, 1'b1, 1'b1, 1'b0);
        send_request(CMD_CANDIDATE, 8'd255, ELEV_MAX, 1'b1, 1'b1, 1'b1);
        // empty epoch after a close
        send_request(CMD_START, 8'd255, ELEV_MAX, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic random_epoch();
        int n, i;
        for (int k = 0; k < 8; k++) begin
            if ($urandom_range(0, 9) == 0) pool_bad[k] = ~pool_bad[k];
            pool_elev[k] = clamp_elev(pool_elev[k] + int'($urandom_range(0, 600)) - 300);
        end
        if ($urandom_range(0, 7) == 0) nat_pick = int'($urandom_range(0, 7));
        n = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 6));
        send_request(CMD_START, pool_ids[nat_pick], pool_elev[nat_pick],
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), n == 0);
        for (int k = 0; k < n; k++) begin
            i = ($urandom_range(0, 3) == 0) ? nat_pick : int'($urandom_range(0, 7));
            send_request(CMD_CANDIDATE, pool_ids[i],
                         clamp_elev(pool_elev[i] + int'($urandom_range(0, 200)) - 100),
                         pool_bad[i] ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 9) == 0),
                         $urandom_range(0, 3) != 0, k == n - 1);
        end
    endtask

    task automatic noise_burst();
        int n;
        case ($urandom_range(0, 2))
            0: begin
                n = int'($urandom_range(1, 4));
                for (int k = 0; k < n; k++)
                    send_request(CMD_CANDIDATE, SAT_W'($urandom_range(0, 255)), any_elev(),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 k == n - 1);
            end
            1: send_request(CMD_START, SAT_W'($urandom_range(0, 255)), any_elev(),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
            default: send_request(1'($urandom_range(0, 1)), SAT_W'($urandom_range(0, 255)),
                                  any_elev(), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        endcase
    endtask

    // suspect streak must hold at 255 for the late switch-away to fire
    task automatic streak_soak();
        send_request(CMD_START, 8'd77, 500, 1'b0, 1'b0, 1'b0);
        send_request(CMD_CANDIDATE, 8'd77, 500, 1'b0, 1'b0, 1'b1);
        repeat (258) begin
            send_request(CMD_START, 8'd77, 500, 1'b0, 1'b0, 1'b0);
            send_request(CMD_CANDIDATE, 8'd77, 500, 1'b1, 1'b0, 1'b1);
        end
        send_request(CMD_START, 8'd77, 500, 1'b0, 1'b0, 1'b0);
        send_request(CMD_CANDIDATE, 8'd77, 500, 1'b1, 1'b0, 1'b0);
        send_request(CMD_CANDIDATE, 8'd78, 400, 1'b0, 1'b1, 1'b1);
    endtask

    task automatic run_phase(input t_idle_mode mode, input int target, input bit soak,
                             input bit hold_off);
        int  base;
        bit  held;
        idle_mode = mode;
        base      = sent_count;
        held      = 1'b0;
        if (soak) streak_soak();
        while (sent_count - base < target) begin
            if (hold_off && !held && sent_count - base >= target / 2) begin
                drain();
                held = 1'b1;
            end
            if ($urandom_range(0, 99) < 85) random_epoch();
            else noise_burst();
        end
        random_epoch();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_SWITCH_EPOCHS;
        i_cfg_data       = '0;
        req_if.valid     = 1'b0;
        req_if.cmd       = CMD_START;
        req_if.sat_id    = '0;
        req_if.elevation = '0;
        req_if.suspect   = 1'b0;
        req_if.dual_freq = 1'b0;
        req_if.last      = 1'b0;
        idle_mode        = IDLE_SENDER_LIGHT;
        sent_count       = 0;
        nat_pick         = 0;
        for (int k = 0; k < 8; k++) begin
            pool_elev[k] = int'($urandom_range(0, 12000)) - 2000;
            pool_bad[k]  = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        apply_settings(1, 0, 31416, -ELEV_MAX);
        directed_requests();

        apply_settings(2, 873, 31416, 0);
        run_phase(IDLE_SENDER_LIGHT, 250, 1'b0, 1'b1);
        apply_settings(0, 31416, 0, ELEV_MAX);
        run_phase(IDLE_SENDER_HEAVY, 250, 1'b0, 1'b0);
        apply_settings(255, 1200, 31416, -ELEV_MAX);
        run_phase(IDLE_NONE, 200, 1'b1, 1'b0);
        apply_settings(3, 500, 5000, -2000);
        run_phase(IDLE_NONE, 200, 1'b0, 1'b0);

        drain();
        repeat (DRAIN_CYCLES + 2) @(negedge i_clk);
        $display("Covered %0d requests, %0d epoch results, %0d reference switches,", sent_count,
                 results, switches);
        $display("over five register settings including range extremes and a 255-epoch soak.");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/rsh_pkg.sv
rtl/rsh_in_if.sv
rtl/rsh_out_if.sv
rtl/rsh_front.sv
rtl/rsh_queue.sv
rtl/rsh_back.sv
rtl/reference_satellite_hysteresis.sv
rtl/rsh_checker.sv
verif/rsh_selection_checker.sv
verif/reference_satellite_hysteresis_tb.sv
